// ===== rtl/bbp_pkg.sv =====
package bbp_pkg;

   // Widths of the datapath.
   localparam int NumW      = 56;   // numerators, remainders and scaled divisors
   localparam int ClipW     = 34;   // clip coordinates, signed, 20 fraction bits
   localparam int SumW      = 35;   // clip sums such as x + w
   localparam int NumLanes  = 5;    // screen_x, screen_y, depth, half_w, half_h
   localparam int DivSteps  = 16;   // one quotient bit per divider stage
   localparam int DivFirst  = 5;    // pipeline index of the first divider stage
   localparam int NumStages = DivFirst + DivSteps + 1;

   // Divider lanes.
   localparam int LaneSx  = 0;
   localparam int LaneSy  = 1;
   localparam int LaneDep = 2;
   localparam int LaneShw = 3;
   localparam int LaneShh = 4;

   typedef logic signed [NumW-1:0] num_type;
   typedef logic [DivSteps-1:0]    quot_type;

   typedef enum logic [2:0] {
      REG_ROW_X  = 3'd0,
      REG_ROW_Y  = 3'd1,
      REG_ROW_Z  = 3'd2,
      REG_ROW_W  = 3'd3,
      REG_VP_W   = 3'd4,
      REG_VP_H   = 3'd5,
      REG_MIN_W  = 3'd6
   } csr_reg_type;

   localparam logic [63:0] RowXReset = 64'h0000_0000_0000_1000;
   localparam logic [63:0] RowYReset = 64'h0000_0000_1000_0000;
   localparam logic [63:0] RowZReset = 64'h0000_1000_0000_0000;
   localparam logic [63:0] RowWReset = 64'h0100_0000_0000_0000;
   localparam logic [12:0] VpWReset  = 13'd640;
   localparam logic [12:0] VpHReset  = 13'd480;
   localparam logic [15:0] MinWReset = 16'd1;

endpackage

// ===== rtl/bbp_req_if.sv =====
interface bbp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic        [15:0] half_width;
   logic        [15:0] half_height;

   modport source (output valid, pos_x, pos_y, pos_z, half_width, half_height,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, half_width, half_height,
                   output ready);
endinterface

// ===== rtl/bbp_rsp_if.sv =====
interface bbp_rsp_if;
   logic               valid;
   logic               ready;
   logic               visible;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic        [15:0] depth;
   logic        [15:0] screen_half_w;
   logic        [15:0] screen_half_h;

   modport source (output valid, visible, screen_x, screen_y, depth, screen_half_w,
                   screen_half_h, input ready);
   modport sink   (input valid, visible, screen_x, screen_y, depth, screen_half_w,
                   screen_half_h, output ready);
endinterface

// ===== rtl/billboard_perspective_projection.sv =====
// Channel  | Direction | Transaction contents
// req_chan | in        | pos_x, pos_y, pos_z (Q8.8), half_width, half_height (Q8.8)
// rsp_chan | out       | visible, screen_x, screen_y (Q12.4), depth (Q0.16), half sizes
// csr_*    | in        | csr_we, csr_index, csr_wdata: one register write per cycle
//
// One transaction enters per cycle unless a stalled response backs up the pipeline.
// The pipeline holds a 16-stage divider that yields one quotient bit per stage.
// Reset is synchronous and loads the identity matrix and a 640 x 480 viewport.
// Every stage holds under a stall and only fills bubbles ahead of it, so a stalled
// response never loses or repeats a transaction.
module billboard_perspective_projection
   import bbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bbp_req_if.sink     req_chan,
   bbp_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // Config registers. Users change them only on an empty pipeline; not enforced.
   logic [63:0] row_ff [4];
   logic [12:0] vp_w_ff;
   logic [12:0] vp_h_ff;
   logic [15:0] min_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= RowXReset;
         row_ff[1] <= RowYReset;
         row_ff[2] <= RowZReset;
         row_ff[3] <= RowWReset;
         vp_w_ff   <= VpWReset;
         vp_h_ff   <= VpHReset;
         min_w_ff  <= MinWReset;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROW_X: row_ff[0] <= csr_wdata;
            REG_ROW_Y: row_ff[1] <= csr_wdata;
            REG_ROW_Z: row_ff[2] <= csr_wdata;
            REG_ROW_W: row_ff[3] <= csr_wdata;
            REG_VP_W:  vp_w_ff   <= csr_wdata[12:0];
            REG_VP_H:  vp_h_ff   <= csr_wdata[12:0];
            REG_MIN_W: min_w_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Stage valid bits and the stall chain. A stage loads when it is empty or
   // when the stage after it loads.
   logic [NumStages-1:0] v_ff;
   logic [NumStages:0]   en;

   always_comb begin
      en[NumStages] = rsp_chan.ready;
      for (int k = NumStages - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NumStages; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? req_chan.valid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign req_chan.ready = en[0];

   // Stage 0: the twelve coefficient products of the matrix.
   logic signed [31:0] prod_ff [4][3];
   logic        [15:0] hw0_ff, hh0_ff;
   logic signed [15:0] pos [3];

   assign pos[0] = req_chan.pos_x;
   assign pos[1] = req_chan.pos_y;
   assign pos[2] = req_chan.pos_z;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(row_ff[r][16*c +: 16]) * pos[c];
            end
         end
         hw0_ff <= req_chan.half_width;
         hh0_ff <= req_chan.half_height;
      end
   end

   // Stage 1: clip coordinates with 20 fraction bits, translation included.
   logic signed [ClipW-1:0] clip_ff [4];
   logic        [15:0]      hw1_ff, hh1_ff;
   logic signed [ClipW-1:0] clip_in [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         clip_in[r] = ClipW'(prod_ff[r][0]) + ClipW'(prod_ff[r][1])
                    + ClipW'(prod_ff[r][2])
                    + $signed({{(ClipW-28){row_ff[r][63]}}, row_ff[r][63:48], 12'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         clip_ff <= clip_in;
         hw1_ff  <= hw0_ff;
         hh1_ff  <= hh0_ff;
      end
   end

   // Stage 2: the sums that feed the numerators, the world half-size times the
   // viewport size, and the hidden test on clip w.
   logic signed [SumW-1:0]  sa_ff, sb_ff, sc_ff;
   logic signed [ClipW-1:0] w2_ff;
   logic        [28:0]      hwv2_ff, hhv2_ff;
   logic                    hid2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sa_ff   <= SumW'(clip_ff[0]) + SumW'(clip_ff[3]);
         sb_ff   <= SumW'(clip_ff[3]) - SumW'(clip_ff[1]);
         sc_ff   <= SumW'(clip_ff[2]) + SumW'(clip_ff[3]);
         w2_ff   <= clip_ff[3];
         hwv2_ff <= hw1_ff * vp_w_ff;
         hhv2_ff <= hh1_ff * vp_h_ff;
         hid2_ff <= (clip_ff[3] <= 0)
                 || (clip_ff[3] < $signed({{(ClipW-28){1'b0}}, min_w_ff, 12'b0}));
      end
   end

   // Stage 3: scale the x and y sums by 16 times the viewport size.
   logic signed [SumW+17:0] ma_ff, mb_ff;
   logic signed [SumW-1:0]  sc3_ff;
   logic signed [ClipW-1:0] w3_ff;
   logic        [28:0]      hwv3_ff, hhv3_ff;
   logic                    hid3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ma_ff   <= sa_ff * $signed({1'b0, vp_w_ff, 4'b0});
         mb_ff   <= sb_ff * $signed({1'b0, vp_h_ff, 4'b0});
         sc3_ff  <= sc_ff;
         w3_ff   <= w2_ff;
         hwv3_ff <= hwv2_ff;
         hhv3_ff <= hhv2_ff;
         hid3_ff <= hid2_ff;
      end
   end

   // Stage 4: numerators with the rounding term w added. The signed outputs
   // also get 2^15 times the divisor so that their quotient is offset binary.
   num_type num_ff [NumLanes];
   num_type den_ff;
   logic    hid4_ff;
   num_type wide_w;

   assign wide_w = num_type'(w3_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         num_ff[LaneSx]  <= num_type'(ma_ff) + wide_w + (wide_w <<< 16);
         num_ff[LaneSy]  <= num_type'(mb_ff) + wide_w + (wide_w <<< 16);
         num_ff[LaneDep] <= (num_type'(sc3_ff) <<< 16) + wide_w;
         num_ff[LaneShw] <= num_type'({hwv3_ff, 16'b0}) + wide_w;
         num_ff[LaneShh] <= num_type'({hhv3_ff, 16'b0}) + wide_w;
         den_ff          <= wide_w <<< 1;
         hid4_ff         <= hid3_ff;
      end
   end

   // Stages 5 to 20: the shared divider.
   quot_type quot [NumLanes];

   bbp_divider u_divider (
      .clock (clock),
      .en    (en[DivFirst +: DivSteps]),
      .num   (num_ff),
      .den   (den_ff),
      .quot  (quot)
   );

   logic hid_ff [DivSteps];

   always_ff @(posedge clock) begin
      for (int j = 0; j < DivSteps; j++) begin
         if (en[DivFirst + j]) begin
            hid_ff[j] <= (j == 0) ? hid4_ff : hid_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // Stage 21: output register. A hidden sprite reports zeros.
   logic        vis_ff;
   logic [15:0] sx_ff, sy_ff, dep_ff, shw_ff, shh_ff;
   logic        hid_out;

   assign hid_out = hid_ff[DivSteps-1];

   always_ff @(posedge clock) begin
      if (en[NumStages-1]) begin
         vis_ff <= !hid_out;
         sx_ff  <= hid_out ? '0 : {~quot[LaneSx][15], quot[LaneSx][14:0]};
         sy_ff  <= hid_out ? '0 : {~quot[LaneSy][15], quot[LaneSy][14:0]};
         dep_ff <= hid_out ? '0 : quot[LaneDep];
         shw_ff <= hid_out ? '0 : quot[LaneShw];
         shh_ff <= hid_out ? '0 : quot[LaneShh];
      end
   end

   assign rsp_chan.valid         = v_ff[NumStages-1];
   assign rsp_chan.visible       = vis_ff;
   assign rsp_chan.screen_x      = $signed(sx_ff);
   assign rsp_chan.screen_y      = $signed(sy_ff);
   assign rsp_chan.depth         = dep_ff;
   assign rsp_chan.screen_half_w = shw_ff;
   assign rsp_chan.screen_half_h = shh_ff;

endmodule

// ===== rtl/bbp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, all lanes sharing
// one divisor. The quotient saturates to all ones when the numerator is at least
// divisor times 2^16, and otherwise to 0 for a negative numerator.
module bbp_divider
   import bbp_pkg::*;
(
   input  logic                clock,
   input  logic [DivSteps-1:0] en,
   input  num_type             num    [NumLanes],
   input  num_type             den,
   output quot_type            quot   [NumLanes]
);

   num_type  rem_ff  [DivSteps][NumLanes];
   quot_type q_ff    [DivSteps][NumLanes];
   logic     lo_ff   [DivSteps][NumLanes];
   logic     hi_ff   [DivSteps][NumLanes];
   num_type  den_ff  [DivSteps];

   for (genvar j = 0; j < DivSteps; j++) begin : g_step
      localparam int Bit = DivSteps - 1 - j;
      num_type  rem_src [NumLanes];
      quot_type q_src   [NumLanes];
      logic     lo_src  [NumLanes];
      logic     hi_src  [NumLanes];
      num_type  den_src;
      num_type  den_sh;
      num_type  rem_in  [NumLanes];
      quot_type q_in    [NumLanes];

      always_comb begin
         if (j == 0) begin
            den_src = den;
         end else begin
            den_src = den_ff[(j == 0) ? 0 : j-1];
         end
         den_sh = den_src <<< Bit;
         for (int l = 0; l < NumLanes; l++) begin
            if (j == 0) begin
               lo_src[l]  = num[l] < 0;
               hi_src[l]  = num[l] >= (den <<< DivSteps);
               rem_src[l] = (lo_src[l] || hi_src[l]) ? '0 : num[l];
               q_src[l]   = '0;
            end else begin
               lo_src[l]  = lo_ff[(j == 0) ? 0 : j-1][l];
               hi_src[l]  = hi_ff[(j == 0) ? 0 : j-1][l];
               rem_src[l] = rem_ff[(j == 0) ? 0 : j-1][l];
               q_src[l]   = q_ff[(j == 0) ? 0 : j-1][l];
            end
            q_in[l]   = q_src[l];
            rem_in[l] = rem_src[l];
            if (rem_src[l] >= den_sh) begin
               rem_in[l]    = rem_src[l] - den_sh;
               q_in[l][Bit] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            den_ff[j] <= den_src;
            for (int l = 0; l < NumLanes; l++) begin
               rem_ff[j][l] <= rem_in[l];
               q_ff[j][l]   <= q_in[l];
               lo_ff[j][l]  <= lo_src[l];
               hi_ff[j][l]  <= hi_src[l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
         if (hi_ff[DivSteps-1][l]) begin
            quot[l] = '1;
         end else if (lo_ff[DivSteps-1][l]) begin
            quot[l] = '0;
         end else begin
            quot[l] = q_ff[DivSteps-1][l];
         end
      end
   end

endmodule

// ===== rtl/bbp_checker.sv =====
module bbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        visible,
   input logic [15:0] screen_x,
   input logic [15:0] screen_y,
   input logic [15:0] depth,
   input logic [15:0] screen_half_w,
   input logic [15:0] screen_half_h
);

   // A pending response stays offered until it is taken.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(screen_x) && $stable(depth)
                               && $stable(visible))
      else $error("response changed while stalled");

   // A hidden sprite carries only zeros.
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !visible |-> screen_x == 16'd0 && screen_y == 16'd0
         && depth == 16'd0 && screen_half_w == 16'd0 && screen_half_h == 16'd0)
      else $error("hidden sprite with nonzero outputs");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind billboard_perspective_projection bbp_checker u_bbp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .visible       (rsp_chan.visible),
   .screen_x      (rsp_chan.screen_x),
   .screen_y      (rsp_chan.screen_y),
   .depth         (rsp_chan.depth),
   .screen_half_w (rsp_chan.screen_half_w),
   .screen_half_h (rsp_chan.screen_half_h)
);
